FILE: rtl/core/sitc_pkg.sv
// Shared constants, types and sizing helpers for the signed integer to ASCII converter.
package sitc_pkg;

    localparam int VALUE_BITS_DEF = 32;
    // Binary bits consumed by each double-dabble stage (the last stage may take fewer)
    localparam int DD_STEP        = 4;

    typedef logic [5:0] ascii_t;

    localparam ascii_t CHAR_ZERO  = 6'd48;
    localparam ascii_t CHAR_MINUS = 6'd45;

    // Decimal digits of the largest magnitude, 2**(bits-1); 1233/4096 ~ log10(2)
    function automatic int digit_count(input int bits);
        return (((bits - 1) * 1233) >> 12) + 1;
    endfunction

endpackage

FILE: rtl/core/signed_int_to_decimal_ascii.sv
// Top level: signed two's complement integer to decimal ASCII character stream.
// Pipeline from input beat to first character:
//   magnitude stage, one double-dabble stage per four bits, serializer load, output register.
// Throughput: one character per cycle on the output while m_ready is high; a value has
//   1 to 11 characters at 32 bits, and the pipeline keeps filling while the serializer sends them.
// Reset: synchronous active-low aresetn clears all valid and busy flags; data is not reset.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = sitc_pkg::VALUE_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [VALUE_BITS-1:0]  s_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output sitc_pkg::ascii_t       m_text_char,
    output logic                   m_last
);
    import sitc_pkg::*;

    localparam int DIGITS  = digit_count(VALUE_BITS);
    localparam int W       = 4 * DIGITS + VALUE_BITS;
    localparam int NSTAGES = (VALUE_BITS + DD_STEP - 1) / DD_STEP;

    logic [NSTAGES:0] st_valid;
    logic [NSTAGES:0] st_ready;
    logic [NSTAGES:0] st_neg;
    logic [W-1:0]     st_work [NSTAGES+1];

    sitc_front #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_value  (s_value),
        .out_valid (st_valid[0]),
        .out_ready (st_ready[0]),
        .out_neg   (st_neg[0]),
        .out_work  (st_work[0])
    );

    for (genvar k = 0; k < NSTAGES; k++) begin : g_dd
        localparam int LEFT  = VALUE_BITS - k * DD_STEP;
        localparam int STEPS = (LEFT < DD_STEP) ? LEFT : DD_STEP;

        sitc_dd_stage #(
            .VALUE_BITS (VALUE_BITS),
            .DIGITS     (DIGITS),
            .STEPS      (STEPS)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (st_valid[k]),
            .in_ready  (st_ready[k]),
            .in_neg    (st_neg[k]),
            .in_work   (st_work[k]),
            .out_valid (st_valid[k+1]),
            .out_ready (st_ready[k+1]),
            .out_neg   (st_neg[k+1]),
            .out_work  (st_work[k+1])
        );
    end

    sitc_serializer #(
        .DIGITS (DIGITS)
    ) u_ser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (st_valid[NSTAGES]),
        .in_ready    (st_ready[NSTAGES]),
        .in_neg      (st_neg[NSTAGES]),
        .in_bcd      (st_work[NSTAGES][W-1:VALUE_BITS]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_text_char (m_text_char),
        .m_last      (m_last)
    );

endmodule

FILE: rtl/core/sitc_front.sv
// Input stage: registers the sign and the unsigned magnitude of the incoming value.
module sitc_front #(
    parameter int VALUE_BITS = 32,
    parameter int DIGITS     = 10
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [VALUE_BITS-1:0]            in_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             out_neg,
    output logic [4*DIGITS+VALUE_BITS-1:0]   out_work
);
    import sitc_pkg::*;

    logic                  valid_reg;
    logic                  neg_reg;
    logic [VALUE_BITS-1:0] mag_reg;
    logic                  neg_next;
    logic [VALUE_BITS-1:0] mag_next;

    // most negative value negates to 2**(VALUE_BITS-1), correct as unsigned
    assign neg_next = in_value[VALUE_BITS-1];
    assign mag_next = neg_next ? (~in_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : in_value;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_neg   = neg_reg;
    assign out_work  = {{(4*DIGITS){1'b0}}, mag_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            neg_reg <= neg_next;
            mag_reg <= mag_next;
        end
    end

endmodule

FILE: rtl/core/sitc_dd_stage.sv
// One double-dabble pipeline stage: shifts STEPS binary bits into the BCD digits.
module sitc_dd_stage #(
    parameter int VALUE_BITS = 32,
    parameter int DIGITS     = 10,
    parameter int STEPS      = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             in_neg,
    input  logic [4*DIGITS+VALUE_BITS-1:0]   in_work,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             out_neg,
    output logic [4*DIGITS+VALUE_BITS-1:0]   out_work
);
    import sitc_pkg::*;

    logic                             valid_reg;
    logic                             neg_reg;
    logic [4*DIGITS+VALUE_BITS-1:0]   work_reg;
    logic [4*DIGITS+VALUE_BITS-1:0]   work_next;

    // work = {bcd digits, remaining binary}; add 3 to digits >= 5, then shift
    always_comb begin
        work_next = in_work;
        for (int s = 0; s < STEPS; s++) begin
            for (int d = 0; d < DIGITS; d++) begin
                if (work_next[VALUE_BITS+4*d +: 4] >= 4'd5) begin
                    work_next[VALUE_BITS+4*d +: 4] = work_next[VALUE_BITS+4*d +: 4] + 4'd3;
                end
            end
            work_next = work_next << 1;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_neg   = neg_reg;
    assign out_work  = work_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            neg_reg  <= in_neg;
            work_reg <= work_next;
        end
    end

endmodule

FILE: rtl/core/sitc_serializer.sv
// Character serializer: skips leading zeros and sends sign and digits one beat each.
module sitc_serializer #(
    parameter int DIGITS = 10
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   in_neg,
    input  logic [4*DIGITS-1:0]    in_bcd,
    output logic                   m_valid,
    input  logic                   m_ready,
    output sitc_pkg::ascii_t       m_text_char,
    output logic                   m_last
);
    import sitc_pkg::*;

    localparam int IDX_BITS = $clog2(DIGITS);

    logic                  busy_reg;
    logic                  sign_reg;
    logic [IDX_BITS-1:0]   idx_reg;
    logic [4*DIGITS-1:0]   bcd_reg;
    logic                  m_valid_reg;
    ascii_t                char_reg;
    logic                  last_reg;

    logic                  out_load;
    logic                  finishing;
    logic [3:0]            cur_digit;
    logic [IDX_BITS-1:0]   lead_idx;

    // highest nonzero digit; zero keeps index 0 and prints a single '0'
    always_comb begin
        lead_idx = '0;
        for (int d = 0; d < DIGITS; d++) begin
            if (in_bcd[4*d +: 4] != 4'd0) begin
                lead_idx = IDX_BITS'(d);
            end
        end
    end

    assign out_load  = !m_valid_reg || m_ready;
    assign cur_digit = bcd_reg[idx_reg*4 +: 4];
    assign finishing = busy_reg && out_load && !sign_reg && (idx_reg == '0);
    assign in_ready  = !busy_reg || finishing;

    assign m_valid     = m_valid_reg;
    assign m_text_char = char_reg;
    assign m_last      = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= busy_reg;
            end
            if (in_valid && in_ready) begin
                busy_reg <= 1'b1;
            end else if (finishing) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg && out_load) begin
            if (sign_reg) begin
                char_reg <= CHAR_MINUS;
                last_reg <= 1'b0;
                sign_reg <= 1'b0;
            end else begin
                char_reg <= CHAR_ZERO + {2'b00, cur_digit};
                last_reg <= (idx_reg == '0);
                if (idx_reg != '0) begin
                    idx_reg <= idx_reg - {{(IDX_BITS-1){1'b0}}, 1'b1};
                end
            end
        end
        if (in_valid && in_ready) begin
            sign_reg <= in_neg;
            idx_reg  <= lead_idx;
            bcd_reg  <= in_bcd;
        end
    end

endmodule

FILE: tb/sv/signed_int_to_decimal_ascii_test.sv
// Self-checking testbench for signed_int_to_decimal_ascii: random and corner values, checked char by char.
module signed_int_to_decimal_ascii_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sitc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_PER_PHASE = 60;

    typedef struct packed {
        ascii_t text_char;
        logic   last;
    } text_beat_t;

    // Expected character stream for every accepted value, oldest first
    class DecimalTextBoard;
        text_beat_t pending_chars[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        function void note_value(logic [31:0] value);
            logic [31:0] magnitude;
            ascii_t      digit_chars[$];
            text_beat_t  beat;
            magnitude = value[31] ? (~value + 32'd1) : value;
            if (magnitude == 32'd0) begin
                beat.text_char = CHAR_ZERO;
                beat.last = 1'b1;
                pending_chars.push_back(beat);
                return;
            end
            while (magnitude != 32'd0) begin
                digit_chars.push_front(CHAR_ZERO + ascii_t'(magnitude % 32'd10));
                magnitude = magnitude / 32'd10;
            end
            if (value[31]) begin
                beat.text_char = CHAR_MINUS;
                beat.last = 1'b0;
                pending_chars.push_back(beat);
            end
            foreach (digit_chars[i]) begin
                beat.text_char = digit_chars[i];
                beat.last = (i == digit_chars.size() - 1);
                pending_chars.push_back(beat);
            end
        endfunction

        function void check_char(ascii_t text_char, logic last);
            text_beat_t want;
            if (pending_chars.size() == 0) begin
                $error("unexpected beat: text_char=%0d last=%0b", text_char, last);
                errors++;
                return;
            end
            want = pending_chars.pop_front();
            if (text_char !== want.text_char) begin
                $error("text_char: expected %0d, got %0d", want.text_char, text_char);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    ascii_t      m_text_char;
    logic        m_last;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;

    DecimalTextBoard board = new();

    signed_int_to_decimal_ascii u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_text_char (m_text_char),
        .m_last      (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                board.note_value(s_value);
            if (m_valid && m_ready)
                board.check_char(m_text_char, m_last);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_value(input logic [31:0] value);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            repeat ($urandom_range(1, 4)) @(negedge aclk) s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_text();
        @(negedge aclk) s_valid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_value();
        longint lo;
        longint hi;
        longint v;
        int     ndigits;
        v = 0;
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: v = $urandom_range(0, 20);
            2: begin
                // uniform over digit count, not over value
                ndigits = $urandom_range(1, 10);
                lo = 1;
                repeat (ndigits - 1) lo = lo * 10;
                hi = (ndigits == 10) ? 64'd2147483647 : lo * 10 - 1;
                v = lo + longint'($urandom_range(0, int'(hi - lo)));
            end
            3: begin
                v = 1;
                repeat ($urandom_range(0, 9)) v = v * 10;
                v = v + $urandom_range(0, 2) - 1;
            end
            default: begin
                case ($urandom_range(0, 2))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    default: return 32'h0;
                endcase
            end
        endcase
        if ($urandom_range(0, 1))
            v = -v;
        return v[31:0];
    endfunction

    initial begin
        logic [31:0] directed_values[$];
        int          send_idle_phase[4];
        int          recv_stall_phase[4];
        directed_values = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99,
                            32'd100, -32'sd100, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h8000_0001, 32'd1000000000, -32'sd999999999,
                            32'd1234567890, -32'sd1234567890, 32'h5555_5555,
                            32'hAAAA_AAAA, 32'd7, -32'sd7};
        send_idle_phase = '{0, 66, 0, 20};
        recv_stall_phase = '{0, 0, 66, 20};

        repeat (6) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        foreach (directed_values[i])
            send_value(directed_values[i]);
        // hold off the sender until every char has come out
        drain_text();

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct = send_idle_phase[phase];
            recv_stall_pct = recv_stall_phase[phase];
            repeat (RANDOM_PER_PHASE)
                send_value(random_value());
            drain_text();
        end

        if (board.errors == 0 && board.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
